// File: rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int unsigned MAX_BLOCKS_DEF   = 64;
	localparam int unsigned HEADER_BYTES_DEF = 8;

	localparam logic [31:0] HEAP_START_RST = 32'h0010_1000;
	localparam logic [31:0] HEAP_LIMIT_RST = 32'h0040_0000;

	localparam int unsigned SIZE_W = 23;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_IGNORED  = 2'd1,
		ST_NOSPACE  = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// register index on the APB port
	typedef enum logic {
		REG_HEAP_START = 1'b0,
		REG_HEAP_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t              command;
		logic [SIZE_W-1:0] request_size;
		logic [31:0]       free_address;
	} req_t;

	typedef struct packed {
		logic [31:0] block_address;
		status_t     status;
		logic [31:0] bytes_used;
		logic [31:0] heap_top;
		logic [31:0] heap_remaining;
	} rsp_t;

	// one block record as stored in the table RAM
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        used;
	} entry_t;

endpackage

// File: rtl/ffha_ram.sv
module ffha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over a table of block records (data address, size, used mark).
// Request channel (req_valid/req_ready/req): one allocate or free command per transfer.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one result per request, in order.
// Config: APB port, heap_start at 0x0, heap_limit at 0x4; a heap_start write re-inits the heap.
// An ignored command (zero size, null address) or a free on an empty table goes straight to
// the result, and an allocate on an empty table straight to an append at the top pointer.
// Otherwise the table RAM is read one record per cycle, and an allocate that finds no fit
// falls through to an append at the top pointer.
// Throughput: one request at a time; req_ready is high only while the sequencer is idle,
// which it is again in the cycle rsp_valid rises. The result sits in an output register, so
// a new request is taken while the previous result still waits for rsp_ready. If the
// receiver stalls, the sequencer holds its finished result until the output register
// frees up.
// Reset: the table is empty, top pointer = heap_start reset value, used bytes = 0. Records
// beyond the fill count are never read, so the RAM needs no clearing pass.
module first_fit_heap_allocator #(
	parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	// request channel
	input  logic            req_valid,
	output logic            req_ready,
	input  ffha_pkg::req_t  req,
	// response channel
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ffha_pkg::rsp_t  rsp,
	// APB config port
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);     // record index
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1); // fill count
	localparam int unsigned EW = $bits(ffha_pkg::entry_t);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_APPEND = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t              state_q;
	logic [31:0]         heap_start_q;
	logic [31:0]         heap_limit_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         top_q;
	logic [31:0]         used_q;

	ffha_pkg::req_t      req_q;
	logic [31:0]         res_addr_q;
	ffha_pkg::status_t   res_status_q;

	logic [CW-1:0]       scan_idx_q;
	logic                data_vld_s1;
	logic [IW-1:0]       data_idx_s1;

	ffha_pkg::rsp_t      rsp_q;
	logic                rsp_valid_q;

	// table RAM
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	ffha_pkg::entry_t    ram_wdata;
	logic                ram_re;
	ffha_pkg::entry_t    ram_rdata;

	logic                req_acc;
	logic                cfg_wr;
	logic                is_free;
	logic                match;
	logic                last_rec;
	logic [33:0]         append_end;
	logic                fits;
	logic [31:0]         hdr32;
	logic [31:0]         req_size32;
	logic                out_free;

	assign hdr32      = 32'(HEADER_BYTES);
	assign req_size32 = {{(32-ffha_pkg::SIZE_W){1'b0}}, req_q.request_size};
	assign is_free    = (req_q.command == ffha_pkg::CMD_FREE);

	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;

	// APB: pready tied high, so never a wait state; write at the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		case (ffha_pkg::reg_idx_t'(paddr[2]))
			ffha_pkg::REG_HEAP_START: prdata = heap_start_q;
			ffha_pkg::REG_HEAP_LIMIT: prdata = heap_limit_q;
			default:                  prdata = heap_start_q;
		endcase
	end

	// scan: one read issued per cycle, compare in the cycle after on registered data
	assign ram_re   = (state_q == S_SCAN) && (scan_idx_q < count_q);
	assign last_rec = (CW'(data_idx_s1) + CW'(1)) == count_q;

	always_comb begin
		if (is_free) begin
			match = data_vld_s1 && (ram_rdata.start == req_q.free_address);
		end else begin
			match = data_vld_s1 && !ram_rdata.used && (ram_rdata.size >= req_size32);
		end
	end

	// append check, no wrap
	assign append_end = {2'b00, top_q} + {2'b00, hdr32} + {2'b00, req_size32};
	assign fits       = (count_q != CW'(MAX_BLOCKS)) && (append_end <= {2'b00, heap_limit_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = data_idx_s1;
		ram_wdata = ram_rdata;
		if (state_q == S_SCAN && match) begin
			// reuse or release in place; record keeps its address and size
			ram_we         = 1'b1;
			ram_wdata.used = !is_free;
		end else if (state_q == S_APPEND && fits) begin
			ram_we          = 1'b1;
			ram_waddr       = count_q[IW-1:0];
			ram_wdata.start = top_q + hdr32;
			ram_wdata.size  = req_size32;
			ram_wdata.used  = 1'b1;
		end
	end

	ffha_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_idx_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign out_free = !rsp_valid_q || rsp_ready;

	// sequencer and heap state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_start_q <= ffha_pkg::HEAP_START_RST;
			heap_limit_q <= ffha_pkg::HEAP_LIMIT_RST;
			count_q      <= '0;
			top_q        <= ffha_pkg::HEAP_START_RST;
			used_q       <= '0;
			scan_idx_q   <= '0;
			data_vld_s1  <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (ffha_pkg::reg_idx_t'(paddr[2]))
					ffha_pkg::REG_HEAP_START: begin
						heap_start_q <= pwdata;
						count_q      <= '0;
						top_q        <= pwdata;
						used_q       <= '0;
					end
					ffha_pkg::REG_HEAP_LIMIT: heap_limit_q <= pwdata;
					default: ;
				endcase
			end

			// output register: load a finished result, or drop the one just taken
			if (state_q == S_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						scan_idx_q  <= '0;
						data_vld_s1 <= 1'b0;
						res_addr_q  <= '0;
						if ((req.command == ffha_pkg::CMD_ALLOC && req.request_size == '0) ||
								(req.command == ffha_pkg::CMD_FREE && req.free_address == '0)) begin
							res_status_q <= ffha_pkg::ST_IGNORED;
							state_q      <= S_RESULT;
						end else if (count_q == '0) begin
							if (req.command == ffha_pkg::CMD_FREE) begin
								res_status_q <= ffha_pkg::ST_NOTFOUND;
								state_q      <= S_RESULT;
							end else begin
								state_q <= S_APPEND;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (ram_re) begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end
					data_vld_s1 <= ram_re;
					data_idx_s1 <= scan_idx_q[IW-1:0];
					if (match) begin
						res_status_q <= ffha_pkg::ST_OK;
						if (is_free) begin
							// drifts as in the scheme: size of record, even if already free
							used_q <= used_q - (ram_rdata.size + hdr32);
						end else begin
							used_q     <= used_q + req_size32 + hdr32;
							res_addr_q <= ram_rdata.start;
						end
						state_q <= S_RESULT;
					end else if (data_vld_s1 && last_rec) begin
						if (is_free) begin
							res_status_q <= ffha_pkg::ST_NOTFOUND;
							state_q      <= S_RESULT;
						end else begin
							state_q <= S_APPEND;
						end
					end
				end
				S_APPEND: begin
					if (fits) begin
						res_status_q <= ffha_pkg::ST_OK;
						res_addr_q   <= top_q + hdr32;
						count_q      <= count_q + CW'(1);
						top_q        <= append_end[31:0];
						used_q       <= used_q + hdr32 + req_size32;
					end else begin
						res_status_q <= ffha_pkg::ST_NOSPACE;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		if (state_q == S_RESULT && out_free) begin
			rsp_q.block_address  <= res_addr_q;
			rsp_q.status         <= res_status_q;
			rsp_q.bytes_used     <= used_q;
			rsp_q.heap_top       <= top_q;
			rsp_q.heap_remaining <= heap_limit_q - top_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
